// ===== rtl/sws_pkg.sv =====
package sws_pkg;

    // Configuration port layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_LO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_HI    = 2'd2;

    // Register widths and reset values
    localparam int WIN_LEN_W = 7;
    localparam int Q_W       = 10;
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = 7'd64;
    localparam logic [Q_W-1:0]       Q_LO_RST    = 10'd500;
    localparam logic [Q_W-1:0]       Q_HI_RST    = 10'd950;

    // Result field widths
    localparam int OUT_W      = 32;
    localparam int FILL_OUT_W = 7;
    localparam int IN_W       = 32;

    // Quantile scale and exact reciprocal of 1000 for the rank division
    localparam int Q_MAX       = 1000;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

    // Broadcast controls for the cell ring
    typedef struct packed {
        logic shift;  // push the new word into the age chain
        logic load;   // copy the stored value into the token
        logic step;   // pass tokens to the next cell
        logic count;  // update token rank counters
    } t_cell_ctrl;

endpackage

// ===== rtl/sws_cell.sv =====
module sws_cell #(
    parameter int IDX         = 0,
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                  i_clk,
    input  sws_pkg::t_cell_ctrl                   i_ctrl,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]       i_fill,
    input  logic [SAMPLE_BITS-1:0]                i_shift_val,
    output logic [SAMPLE_BITS-1:0]                o_val,
    input  logic [SAMPLE_BITS-1:0]                i_tok_val,
    input  logic                                  i_tok_vld,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]       i_tok_less,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]       i_tok_eq,
    output logic [SAMPLE_BITS-1:0]                o_tok_val,
    output logic                                  o_tok_vld,
    output logic [$clog2(MAX_WINDOW+1)-1:0]       o_tok_less,
    output logic [$clog2(MAX_WINDOW+1)-1:0]       o_tok_eq
);

    localparam int CW = $clog2(MAX_WINDOW+1);

    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] r_tok_val;
    logic                   r_tok_vld;
    logic [CW-1:0]          r_tok_less;
    logic [CW-1:0]          r_tok_eq;
    logic                   w_own_vld;
    logic                   w_lt;
    logic                   w_eq;

    // This slot holds a live sample when it lies below the fill count
    assign w_own_vld = (i_fill > CW'(IDX));

    assign w_lt = i_ctrl.count && w_own_vld && (r_val < r_tok_val);
    assign w_eq = i_ctrl.count && w_own_vld && (r_val == r_tok_val);

    // Hand the token on with this cell's comparison folded in
    assign o_val      = r_val;
    assign o_tok_val  = r_tok_val;
    assign o_tok_vld  = r_tok_vld;
    assign o_tok_less = r_tok_less + CW'(w_lt);
    assign o_tok_eq   = r_tok_eq + CW'(w_eq);

    // Advance the age chain
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_val <= i_shift_val;
        end
    end

    // Load or pass the token
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_tok_val  <= r_val;
            r_tok_vld  <= w_own_vld;
            r_tok_less <= '0;
            r_tok_eq   <= '0;
        end else if (i_ctrl.step) begin
            r_tok_val  <= i_tok_val;
            r_tok_vld  <= i_tok_vld;
            r_tok_less <= i_tok_less;
            r_tok_eq   <= i_tok_eq;
        end
    end

endmodule

// ===== rtl/sws_rank.sv =====
module sws_rank #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                i_clk,
    input  logic [sws_pkg::Q_W-1:0]             i_quantile,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]     i_fill,
    output logic [$clog2(MAX_WINDOW)-1:0]       o_rank
);

    localparam int CW  = $clog2(MAX_WINDOW+1);
    localparam int RW  = $clog2(MAX_WINDOW);
    localparam int YW  = sws_pkg::Q_W + CW + 1;
    localparam int PRW = YW + sws_pkg::RECIP_W;

    logic [sws_pkg::Q_W-1:0] w_q;
    logic [YW-1:0]           w_y;
    logic [YW-1:0]           r_y;
    logic [PRW-1:0]          w_prod;
    logic [RW-1:0]           r_rank;

    // Saturate the quantile and form q*(n-1)+999 for the ceiling
    always_comb begin
        if (i_quantile > sws_pkg::Q_W'(sws_pkg::Q_MAX)) begin
            w_q = sws_pkg::Q_W'(sws_pkg::Q_MAX);
        end else begin
            w_q = i_quantile;
        end
        w_y = YW'(w_q) * YW'(i_fill - CW'(1)) + YW'(sws_pkg::Q_MAX - 1);
    end

    // Divide by 1000 through the exact reciprocal
    assign w_prod = PRW'(r_y) * PRW'(sws_pkg::RECIP_1000);

    always_ff @(posedge i_clk) begin
        r_y    <= w_y;
        r_rank <= w_prod[sws_pkg::RECIP_SHIFT +: RW];
    end

    assign o_rank = r_rank;

endmodule

// ===== rtl/sws_div.sv =====
module sws_div #(
    parameter int DW = 38,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int KW = $clog2(DW+1);

    logic          r_busy;
    logic [KW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;
    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_fit;
    logic [VW-1:0] n_rem;

    // One restoring step per cycle, quotient bits shift in behind the dividend
    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
        if (w_fit) begin
            n_rem = w_diff[VW-1:0];
        end else begin
            n_rem = w_trial[VW-1:0];
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= KW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - KW'(1);
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/sliding_window_statistics.sv =====
// Sliding window statistics over unsigned UQ24.8 samples.
// Input channel: i_in_valid / o_in_stall with i_sample; a word is taken when
// valid is high and stall is low. Each input word yields one result word on
// o_out_valid / i_out_stall: fill level, truncated mean, min, max and the two
// quantile values. Configuration writes use i_cfg_valid / o_cfg_ready with a
// register index and data; index 0 (window length) also empties the window.
// The window is a ring of MAX_WINDOW cells in age order. After a word enters,
// every cell launches a token that travels the ring once counting smaller and
// equal samples, while cell 0 sums and tracks min and max; a second lap picks
// out the tokens whose rank matches each quantile. The mean divider runs one
// quotient bit per cycle (SAMPLE_BITS + clog2(MAX_WINDOW+1) steps), starting
// as the second lap begins. The result is loaded once the second lap and the
// divider are both done, and the next word is taken only after that; if the
// divider needs more steps than the lap, the result waits for it. Results sit
// in an output register, so a stalled receiver holds the result while the
// next word is processed; the block waits only if a second result is ready
// before the first is taken.
// Reset empties the window and restores the register defaults.
module sliding_window_statistics #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sws_pkg::IN_W-1:0]          i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sws_pkg::FILL_OUT_W-1:0]    o_fill_level,
    output logic [sws_pkg::OUT_W-1:0]         o_window_mean,
    output logic [sws_pkg::OUT_W-1:0]         o_window_min,
    output logic [sws_pkg::OUT_W-1:0]         o_window_max,
    output logic [sws_pkg::OUT_W-1:0]         o_low_quantile_value,
    output logic [sws_pkg::OUT_W-1:0]         o_high_quantile_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sws_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sws_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WINDOW+1);
    localparam int RW = $clog2(MAX_WINDOW);
    localparam int DW = SAMPLE_BITS + CW;
    localparam int SB = SAMPLE_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_LAP1 = 3'd2;
    localparam logic [2:0] ST_LAP2 = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [RW-1:0]                 r_cnt;
    logic                          w_last;
    logic                          w_in_acc;
    logic                          w_cfg_acc;
    logic                          w_out_load;
    logic                          r_out_vld;

    logic [sws_pkg::WIN_LEN_W-1:0] r_win_len;
    logic [sws_pkg::Q_W-1:0]       r_q_lo;
    logic [sws_pkg::Q_W-1:0]       r_q_hi;
    logic [CW-1:0]                 r_fill;
    logic [CW-1:0]                 w_len_eff;

    logic [SB-1:0]                 w_sample;
    sws_pkg::t_cell_ctrl           w_ctrl;

    logic [SB-1:0]                 w_cell_val  [MAX_WINDOW];
    logic [SB-1:0]                 w_shift_in  [MAX_WINDOW];
    logic [SB-1:0]                 w_tok_val   [MAX_WINDOW];
    logic                          w_tok_vld   [MAX_WINDOW];
    logic [CW-1:0]                 w_tok_less  [MAX_WINDOW];
    logic [CW-1:0]                 w_tok_eq    [MAX_WINDOW];

    logic [RW-1:0]                 w_rank_lo;
    logic [RW-1:0]                 w_rank_hi;
    logic [CW:0]                   w_less_x;
    logic [CW:0]                   w_upper_x;
    logic                          w_hit_lo;
    logic                          w_hit_hi;

    logic [DW-1:0]                 r_sum;
    logic [SB-1:0]                 r_min;
    logic [SB-1:0]                 r_max;
    logic [SB-1:0]                 r_lo;
    logic [SB-1:0]                 r_hi;
    logic                          w_div_start;
    logic                          w_div_busy;
    logic [DW-1:0]                 w_quot;

    logic [sws_pkg::FILL_OUT_W-1:0] r_o_fill;
    logic [sws_pkg::OUT_W-1:0]      r_o_mean;
    logic [sws_pkg::OUT_W-1:0]      r_o_min;
    logic [sws_pkg::OUT_W-1:0]      r_o_max;
    logic [sws_pkg::OUT_W-1:0]      r_o_lo;
    logic [sws_pkg::OUT_W-1:0]      r_o_hi;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_sample    = SB'(i_sample);
    assign w_last      = (r_cnt == RW'(MAX_WINDOW - 1));
    assign w_out_load  = (r_state == ST_WAIT) && !w_div_busy && (!r_out_vld || !i_out_stall);

    // Effective window length: zero acts as one, saturate at the ring size
    always_comb begin
        if (r_win_len == '0) begin
            w_len_eff = CW'(1);
        end else if (int'(r_win_len) > MAX_WINDOW) begin
            w_len_eff = CW'(MAX_WINDOW);
        end else begin
            w_len_eff = CW'(r_win_len);
        end
    end

    // Configuration registers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= sws_pkg::WIN_LEN_RST;
            r_q_lo    <= sws_pkg::Q_LO_RST;
            r_q_hi    <= sws_pkg::Q_HI_RST;
            r_fill    <= '0;
        end else begin
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    sws_pkg::CFG_WIN_LEN: begin
                        r_win_len <= i_cfg_data[sws_pkg::WIN_LEN_W-1:0];
                        r_fill    <= '0;
                    end
                    sws_pkg::CFG_Q_LO: r_q_lo <= i_cfg_data[sws_pkg::Q_W-1:0];
                    sws_pkg::CFG_Q_HI: r_q_hi <= i_cfg_data[sws_pkg::Q_W-1:0];
                    default: ;
                endcase
            end else if (w_in_acc && (r_fill < w_len_eff)) begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_LAP1;
            ST_LAP1: if (w_last) n_state = ST_LAP2;
            ST_LAP2: if (w_last) n_state = ST_WAIT;
            ST_WAIT: if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_LAP1) || (r_state == ST_LAP2)) begin
                r_cnt <= w_last ? '0 : r_cnt + RW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Ring controls
    always_comb begin
        w_ctrl.shift = w_in_acc;
        w_ctrl.load  = (r_state == ST_LOAD);
        w_ctrl.step  = (r_state == ST_LAP1) || (r_state == ST_LAP2);
        w_ctrl.count = (r_state == ST_LAP1);
    end

    // Ring of cells, newest sample in cell 0
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        localparam int PREV = (g == 0) ? MAX_WINDOW - 1 : g - 1;

        if (g == 0) begin : g_head
            assign w_shift_in[g] = w_sample;
        end else begin : g_body
            assign w_shift_in[g] = w_cell_val[PREV];
        end

        sws_cell #(
            .IDX         (g),
            .MAX_WINDOW  (MAX_WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_fill      (r_fill),
            .i_shift_val (w_shift_in[g]),
            .o_val       (w_cell_val[g]),
            .i_tok_val   (w_tok_val[PREV]),
            .i_tok_vld   (w_tok_vld[PREV]),
            .i_tok_less  (w_tok_less[PREV]),
            .i_tok_eq    (w_tok_eq[PREV]),
            .o_tok_val   (w_tok_val[g]),
            .o_tok_vld   (w_tok_vld[g]),
            .o_tok_less  (w_tok_less[g]),
            .o_tok_eq    (w_tok_eq[g])
        );
    end

    // Quantile ranks
    sws_rank #(.MAX_WINDOW(MAX_WINDOW)) u_rank_lo (
        .i_clk      (i_clk),
        .i_quantile (r_q_lo),
        .i_fill     (r_fill),
        .o_rank     (w_rank_lo)
    );

    sws_rank #(.MAX_WINDOW(MAX_WINDOW)) u_rank_hi (
        .i_clk      (i_clk),
        .i_quantile (r_q_hi),
        .i_fill     (r_fill),
        .o_rank     (w_rank_hi)
    );

    // Rank match for the token passing cell 0
    always_comb begin
        w_less_x  = {1'b0, w_tok_less[0]};
        w_upper_x = {1'b0, w_tok_less[0]} + {1'b0, w_tok_eq[0]};
        w_hit_lo  = (w_less_x <= (CW+1)'(w_rank_lo)) && ((CW+1)'(w_rank_lo) < w_upper_x);
        w_hit_hi  = (w_less_x <= (CW+1)'(w_rank_hi)) && ((CW+1)'(w_rank_hi) < w_upper_x);
    end

    // Mean divider, started as the second lap begins
    assign w_div_start = (r_state == ST_LAP2) && (r_cnt == '0);

    sws_div #(.DW(DW), .VW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_busy     (w_div_busy),
        .o_quotient (w_quot)
    );

    // Collect sum, extremes and quantiles at cell 0
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if ((r_state == ST_LAP1) && w_tok_vld[0]) begin
            r_sum <= r_sum + DW'(w_tok_val[0]);
            if (w_tok_val[0] < r_min) r_min <= w_tok_val[0];
            if (w_tok_val[0] > r_max) r_max <= w_tok_val[0];
        end
        if ((r_state == ST_LAP2) && w_tok_vld[0]) begin
            if (w_hit_lo) r_lo <= w_tok_val[0];
            if (w_hit_hi) r_hi <= w_tok_val[0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_fill <= sws_pkg::FILL_OUT_W'(r_fill);
            r_o_mean <= sws_pkg::OUT_W'(w_quot);
            r_o_min  <= sws_pkg::OUT_W'(r_min);
            r_o_max  <= sws_pkg::OUT_W'(r_max);
            r_o_lo   <= sws_pkg::OUT_W'(r_lo);
            r_o_hi   <= sws_pkg::OUT_W'(r_hi);
        end
    end

    assign o_out_valid           = r_out_vld;
    assign o_fill_level          = r_o_fill;
    assign o_window_mean         = r_o_mean;
    assign o_window_min          = r_o_min;
    assign o_window_max          = r_o_max;
    assign o_low_quantile_value  = r_o_lo;
    assign o_high_quantile_value = r_o_hi;

    // Checks
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in flight");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len_eff)
        else $error("fill count beyond window length");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_WAIT) && !$past(w_div_busy))
        else $error("result loaded before the mean was ready");

endmodule
